// File: sv/lkvc_pkg.sv
`default_nettype none
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CAP_W = 5;
  localparam int DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic signed [DATA_W-1:0] READ_MISS = '1;
  localparam logic signed [DATA_W-1:0] READ_NONE = '0;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_SET = 1'b1
  } action_t;

  typedef struct packed {
    logic                     valid;
    action_t                  action;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
  } resp_t;

endpackage
`default_nettype wire

// File: sv/lru_key_value_cache.sv
`default_nettype none
// Fully associative key-value cache with least-recently-used replacement, 16 entries.
// One get or set transfer is taken every cycle unless the input is stalled; its
// result passes through the input register, then one pass of parallel key compare
// and recency update, into the result register, which offers it. A stalled result
// holds the input register and then stalls the input. The
// store starts empty after reset with no clearing pass. cfg_wr_data sets the capacity
// (0 acts as 1, above 16 as 16); write it only while no transfer is in flight.
module lru_key_value_cache (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [lkvc_pkg::CAP_W-1:0]           cfg_wr_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_action,
  input  wire logic signed [lkvc_pkg::DATA_W-1:0]   in_lookup_key,
  input  wire logic signed [lkvc_pkg::DATA_W-1:0]   in_write_value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_hit,
  output logic signed [lkvc_pkg::DATA_W-1:0]        out_read_value,
  output logic                                      out_evicted
);
  import lkvc_pkg::*;

  logic [CAP_W-1:0]         capacity_r;
  logic                     s1_valid_r;
  action_t                  s1_action_r;
  logic signed [DATA_W-1:0] s1_key_r;
  logic signed [DATA_W-1:0] s1_value_r;
  logic                     out_valid_r;
  resp_t                    out_resp_r;
  logic                     advance;
  req_t                     req;
  resp_t                    resp;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_comb begin
    req.valid  = advance;
    req.action = s1_action_r;
    req.key    = s1_key_r;
    req.value  = s1_value_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
    end
  end

  // advance input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_action_r <= action_t'(in_action);
      s1_key_r    <= in_lookup_key;
      s1_value_r  <= in_write_value;
    end
  end

  // hold result while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_resp_r <= resp;
    end
  end

  lkvc_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .capacity (capacity_r),
    .req      (req),
    .resp     (resp)
  );

  assign out_valid      = out_valid_r;
  assign out_hit        = out_resp_r.hit;
  assign out_read_value = out_resp_r.read_value;
  assign out_evicted    = out_resp_r.evicted;

endmodule
`default_nettype wire

// File: sv/lkvc_store.sv
`default_nettype none
module lkvc_store (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [lkvc_pkg::CAP_W-1:0]  capacity,
  input  wire lkvc_pkg::req_t              req,
  output lkvc_pkg::resp_t                  resp
);
  import lkvc_pkg::*;

  logic [DATA_W-1:0] key_r   [ENTRIES];
  logic [DATA_W-1:0] value_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [IDX_W-1:0]  rec_r   [ENTRIES];
  logic [CNT_W-1:0]  count_r;

  logic [CNT_W-1:0]  cap_eff;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] oldest;
  logic              hit;
  logic [IDX_W-1:0]  hit_rec;
  logic [DATA_W-1:0] hit_value;
  logic [IDX_W-1:0]  old_idx;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  ins_idx;
  logic [IDX_W-1:0]  last_rank;
  logic              is_set;
  logic              evict_en;
  logic              insert_en;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(capacity) > ENTRIES) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  assign last_rank = IDX_W'(count_r - CNT_W'(1));

  always_comb begin
    hit_rec   = '0;
    hit_value = '0;
    old_idx   = '0;
    free_idx  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_r[i] && (key_r[i] == req.key);
      oldest[i] = valid_r[i] && (rec_r[i] == last_rank);
      hit_rec   = hit_rec | (rec_r[i] & {IDX_W{match[i]}});
      hit_value = hit_value | (value_r[i] & {DATA_W{match[i]}});
      if (oldest[i]) begin
        old_idx = IDX_W'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign hit       = |match;
  assign is_set    = (req.action == ACT_SET);
  assign evict_en  = is_set && !hit && (count_r >= cap_eff) && (count_r != '0);
  assign insert_en = req.valid && is_set && !hit;
  assign ins_idx   = evict_en ? old_idx : free_idx;

  always_comb begin
    resp.hit     = hit;
    resp.evicted = evict_en;
    if (is_set) begin
      resp.read_value = READ_NONE;
    end else if (hit) begin
      resp.read_value = hit_value;
    end else begin
      resp.read_value = READ_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rec_r[i] <= '0;
      end
    end else if (req.valid) begin
      if (insert_en && !evict_en) begin
        count_r <= count_r + CNT_W'(1);
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit) begin
          if (match[i]) begin
            rec_r[i] <= '0;
          end else if (valid_r[i] && (rec_r[i] < hit_rec)) begin
            rec_r[i] <= rec_r[i] + IDX_W'(1);
          end
        end else if (is_set) begin
          if (IDX_W'(i) == ins_idx) begin
            valid_r[i] <= 1'b1;
            rec_r[i]   <= '0;
          end else if (valid_r[i]) begin
            rec_r[i] <= rec_r[i] + IDX_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && is_set) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit ? match[i] : (IDX_W'(i) == ins_idx)) begin
          key_r[i]   <= req.key;
          value_r[i] <= req.value;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/lkvc_checker.sv
`default_nettype none
module lkvc_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_stall,
  input wire logic                                 out_valid,
  input wire logic                                 out_stall,
  input wire logic                                 out_hit,
  input wire logic signed [lkvc_pkg::DATA_W-1:0]   out_read_value,
  input wire logic                                 out_evicted
);
  import lkvc_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value) && $stable(out_hit)
      && $stable(out_evicted))
    else $error("stalled result changed");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("hit and eviction together");

  a_evict_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_read_value == READ_NONE)
    else $error("eviction with nonzero read value");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);
`default_nettype wire

// File: sim/testbench.sv
`default_nettype none
module testbench;
  import lkvc_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  logic in_action;
  logic signed [DATA_W-1:0] in_lookup_key;
  logic signed [DATA_W-1:0] in_write_value;
  logic out_valid;
  logic out_stall;
  logic out_hit;
  logic signed [DATA_W-1:0] out_read_value;
  logic out_evicted;

  int hold_requests = 0;
  int holds_done = 0;

  class lru_shadow;
    logic [DATA_W-1:0] slot_key[ENTRIES];
    logic [DATA_W-1:0] slot_data[ENTRIES];
    bit slot_live[ENTRIES];
    int unsigned slot_rank[ENTRIES];
    int unsigned live_count;
    logic [CAP_W-1:0] capacity;
    resp_t awaited[$];
    int mismatches;

    function new();
      foreach (slot_live[i]) begin
        slot_live[i] = 1'b0;
        slot_rank[i] = 0;
      end
      live_count = 0;
      capacity = CAP_RESET;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] v);
      capacity = v;
    endfunction

    function int unsigned usable_slots();
      int unsigned c;
      c = capacity;
      if (c == 0) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function int locate(logic [DATA_W-1:0] key);
      for (int i = 0; i < ENTRIES; i++)
        if (slot_live[i] && slot_key[i] == key) return i;
      return -1;
    endfunction

    // make slot s the most recent; younger live entries age by one
    function void promote(int s);
      int unsigned r;
      r = slot_rank[s];
      for (int i = 0; i < ENTRIES; i++)
        if (slot_live[i] && slot_rank[i] < r) slot_rank[i]++;
      slot_rank[s] = 0;
    endfunction

    function void note_request(action_t act, logic [DATA_W-1:0] key,
                               logic [DATA_W-1:0] data);
      resp_t e;
      int s;
      int slot;
      int unsigned oldest;
      s = locate(key);
      e.hit = (s >= 0);
      e.read_value = READ_NONE;
      e.evicted = 1'b0;
      if (act == ACT_GET) begin
        if (s >= 0) begin
          e.read_value = slot_data[s];
          promote(s);
        end else begin
          e.read_value = READ_MISS;
        end
      end else if (s >= 0) begin
        slot_data[s] = data;
        promote(s);
      end else begin
        slot = -1;
        if (live_count >= usable_slots() && live_count > 0) begin
          oldest = 0;
          for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i] && (slot < 0 || slot_rank[i] > oldest)) begin
              slot = i;
              oldest = slot_rank[i];
            end
          if (slot >= 0) begin
            slot_live[slot] = 1'b0;
            live_count--;
            e.evicted = 1'b1;
          end
        end
        if (slot < 0)
          for (int i = 0; i < ENTRIES; i++)
            if (!slot_live[i]) begin
              slot = i;
              break;
            end
        if (slot >= 0) begin
          for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i]) slot_rank[i]++;
          slot_key[slot] = key;
          slot_data[slot] = data;
          slot_live[slot] = 1'b1;
          slot_rank[slot] = 0;
          live_count++;
        end
      end
      awaited.push_back(e);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 50) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_response(logic hit, logic signed [DATA_W-1:0] rd, logic ev);
      resp_t e;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing awaited: hit=%0b read=%0d evicted=%0b",
                         hit, rd, ev));
        return;
      end
      e = awaited.pop_front();
      if (hit !== e.hit)
        report($sformatf("hit %0b, expected %0b", hit, e.hit));
      if (rd !== e.read_value)
        report($sformatf("read_value %0d, expected %0d", rd, e.read_value));
      if (ev !== e.evicted)
        report($sformatf("evicted %0b, expected %0b", ev, e.evicted));
    endtask
  endclass

  lru_shadow shadow = new();

  lru_key_value_cache dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_lookup_key (in_lookup_key),
    .in_write_value(in_write_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_read_value(out_read_value),
    .out_evicted   (out_evicted)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(action_t act, logic [DATA_W-1:0] key, logic [DATA_W-1:0] data);
    in_valid <= 1'b1;
    in_action <= act;
    in_lookup_key <= key;
    in_write_value <= data;
    do @(posedge clk); while (in_stall);
    shadow.note_request(act, key, data);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    idle_cycles(1);
    while (shadow.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow.set_capacity(v);
  endtask

  task automatic run_phase(logic [CAP_W-1:0] cap, int count, bit squeeze);
    logic [DATA_W-1:0] pool[$];
    int unsigned span;
    int burst;
    int sent;
    action_t act;
    logic [DATA_W-1:0] key;
    write_capacity(cap);
    span = shadow.usable_slots() + $urandom_range(1, shadow.usable_slots() + 4);
    for (int i = 0; i < span; i++) pool.push_back(pick_word());
    if (squeeze) hold_requests++;
    sent = 0;
    while (sent < count) begin
      burst = squeeze ? count : $urandom_range(1, 30);
      while (burst > 0 && sent < count) begin
        act = ($urandom_range(0, 99) < 45) ? ACT_SET : ACT_GET;
        key = ($urandom_range(0, 9) == 0) ? $urandom() : pool[$urandom_range(0, span - 1)];
        send_item(act, key, pick_word());
        burst--;
        sent++;
      end
      if (!squeeze && $urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
    end
    drain();
  endtask

  initial begin
    int mode;
    int mode_left;
    int hold_left;
    out_stall <= 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        shadow.check_response(out_hit, out_read_value, out_evicted);
      if (hold_left == 0 && holds_done != hold_requests) begin
        holds_done++;
        hold_left = 100;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    logic [CAP_W-1:0] phase_caps[10];
    phase_caps = '{5'd16, 5'd1, 5'd5, 5'd2, 5'd31, 5'd3, 5'd17, 5'd9, 5'd0, 5'd12};
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    in_action <= ACT_GET;
    in_lookup_key <= '0;
    in_write_value <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(ACT_GET, 32'h0000_0000, 32'hdead_beef);
    send_item(ACT_SET, 32'h8000_0000, 32'h7fff_ffff);
    send_item(ACT_SET, 32'h7fff_ffff, 32'h8000_0000);
    send_item(ACT_SET, 32'hffff_ffff, 32'hffff_ffff);
    send_item(ACT_SET, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_GET, 32'h8000_0000, 32'h0000_0000);
    send_item(ACT_GET, 32'h7fff_ffff, 32'hffff_ffff);
    send_item(ACT_SET, 32'hffff_ffff, 32'h1234_5678);
    send_item(ACT_GET, 32'hffff_ffff, 32'h0000_0000);
    send_item(ACT_GET, 32'h0000_0001, 32'h0000_0000);
    drain();

    // capacity zero behaves as one, below the current occupancy
    write_capacity(5'd0);
    send_item(ACT_SET, 32'h5555_5555, 32'haaaa_aaaa);
    send_item(ACT_GET, 32'h5555_5555, 32'h0000_0000);
    send_item(ACT_SET, 32'haaaa_aaaa, 32'h5555_5555);
    send_item(ACT_GET, 32'h8000_0000, 32'h0000_0000);
    send_item(ACT_SET, 32'haaaa_aaaa, 32'h0000_0001);
    drain();

    // capacity above the entry count saturates
    write_capacity(5'd31);
    for (int i = 0; i < 5; i++)
      send_item(ACT_SET, 32'h0100_0000 + i, 32'hc000_0000 + i);
    send_item(ACT_GET, 32'h0100_0000, 32'h0000_0000);
    send_item(ACT_GET, 32'haaaa_aaaa, 32'h0000_0000);
    drain();

    for (int p = 0; p < 10; p++)
      run_phase(phase_caps[p], 178, (p == 0 || p == 4));

    repeat (10) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: lru_key_value_cache.f
sv/lkvc_pkg.sv
sv/lkvc_store.sv
sv/lru_key_value_cache.sv
sv/lkvc_checker.sv
sim/testbench.sv
